// File: rtl/ptm_pkg.sv
package ptm_pkg;

   localparam int SAMPLE_COUNT_DEF = 5;
   localparam int WRAP_LIMIT_DEF   = 63;

   localparam int CAP_W       = 16;
   localparam int WRAP_W      = 6;
   localparam int SAMPLE_W    = WRAP_W + CAP_W;
   localparam int SUM_W       = SAMPLE_W + 2;
   localparam int AVG_W       = 23;
   localparam int OFFSET_W    = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_USER_W  = 3;
   localparam int RSP_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_MODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESULT_OFFSET = 2'd1;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd3;
   localparam logic [CAP_W-1:0]    CAP_MAX      = 16'hFFFF;

   // ceil(2**(SUM_W+1) / 3): exact floor division by three for SUM_W-bit sums
   localparam int                  DIV3_SHIFT   = SUM_W + 1;
   localparam logic [SUM_W-1:0]    DIV3_RECIP   = 24'hAAAAAB;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SORT,
      ST_DIV,
      ST_OUT
   } flt_state_type;

   typedef enum logic {
      ALU_SUB,
      ALU_ADD
   } alu_op_type;

   typedef struct packed {
      logic                write;
      logic [SAMPLE_W-1:0] value;
   } sample_type;

endpackage

// File: rtl/ptm_ram.sv
module ptm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: rtl/ptm_alu.sv
module ptm_alu (
   input  ptm_pkg::alu_op_type             op,
   input  logic [ptm_pkg::SUM_W-1:0]       a,
   input  logic [ptm_pkg::SUM_W-1:0]       b,
   output logic [ptm_pkg::SUM_W-1:0]       result,
   output logic                            borrow
);

   logic [ptm_pkg::SUM_W:0] full;

   always_comb begin
      unique case (op)
         ptm_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
         ptm_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
         default:          full = '0;
      endcase
   end

   // on subtract the top bit is set when a < b
   assign result = full[ptm_pkg::SUM_W-1:0];
   assign borrow = full[ptm_pkg::SUM_W];

endmodule

// File: rtl/ptm_capture.sv
module ptm_capture #(
   parameter int WRAP_LIMIT = ptm_pkg::WRAP_LIMIT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      overflow,
   input  logic                      edge_seen,
   input  logic                      edge_rising,
   input  logic [ptm_pkg::CAP_W-1:0] capture_count,
   input  logic                      level_mode,
   output ptm_pkg::sample_type       sample
);

   localparam logic [ptm_pkg::WRAP_W-1:0] LIMIT = ptm_pkg::WRAP_W'(WRAP_LIMIT);

   logic                      started_ff, started_in;
   logic [ptm_pkg::WRAP_W-1:0] wrap_ff, wrap_in;
   logic                      expect_ff, expect_in;

   logic                       ovf_act;
   logic                       force_end;
   logic                       started_mid;
   logic [ptm_pkg::WRAP_W-1:0] wrap_mid;
   logic                       expect_mid;
   logic                       match;
   logic                       edge_end;
   logic [ptm_pkg::SAMPLE_W-1:0] meas;

   always_comb begin
      // overflow is handled before the edge
      ovf_act     = overflow && started_ff;
      force_end   = ovf_act && (wrap_ff >= LIMIT);
      started_mid = started_ff && !force_end;
      expect_mid  = expect_ff && !force_end;
      if (force_end) begin
         wrap_mid = '0;
      end else if (ovf_act) begin
         wrap_mid = wrap_ff + 1'b1;
      end else begin
         wrap_mid = wrap_ff;
      end

      match    = edge_seen && !force_end &&
                 (level_mode ? (edge_rising != expect_mid) : edge_rising);
      edge_end = match && started_mid;

      started_in = started_mid;
      wrap_in    = wrap_mid;
      expect_in  = expect_mid;
      if (match) begin
         started_in = !started_mid;
         wrap_in    = '0;
         expect_in  = !started_mid && level_mode;
      end

      meas = force_end ? {LIMIT, ptm_pkg::CAP_MAX} : {wrap_mid, capture_count};

      sample.write = accept && (force_end || edge_end) && (meas != '0);
      sample.value = meas;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         wrap_ff    <= '0;
         expect_ff  <= 1'b0;
      end else if (accept) begin
         started_ff <= started_in;
         wrap_ff    <= wrap_in;
         expect_ff  <= expect_in;
      end
   end

endmodule

// File: rtl/ptm_filter.sv
module ptm_filter #(
   parameter int SAMPLE_COUNT = ptm_pkg::SAMPLE_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ptm_pkg::sample_type          sample,
   input  logic [ptm_pkg::OFFSET_W-1:0] result_offset,
   output logic                         ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ptm_pkg::AVG_W-1:0]    rsp_average_time
);

   localparam int AW     = $clog2(SAMPLE_COUNT);
   localparam int CW     = $clog2(SAMPLE_COUNT + 1);
   localparam int PROD_W = 2 * ptm_pkg::SUM_W;

   localparam logic [AW-1:0] LAST_IDX = AW'(SAMPLE_COUNT - 1);
   localparam logic [CW-1:0] J_END    = CW'(SAMPLE_COUNT);
   localparam logic [AW-1:0] WIN_LO   = AW'(SAMPLE_COUNT / 2 - 1);
   localparam logic [AW-1:0] WIN_HI   = AW'(SAMPLE_COUNT / 2 + 1);

   ptm_pkg::flt_state_type state_ff, state_in;

   logic [AW-1:0]               i_ff, i_in;
   logic [CW-1:0]               j_ff, j_in;
   logic [AW-1:0]               rank_ff, rank_in;
   logic [AW-1:0]               fill_ff, fill_in;
   logic [ptm_pkg::SUM_W-1:0]   acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ptm_pkg::AVG_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [ptm_pkg::SAMPLE_W-1:0] rd_a;
   logic [ptm_pkg::SAMPLE_W-1:0] rd_b;
   logic [AW-1:0]                rd_addr_b;

   ptm_pkg::alu_op_type         alu_op;
   logic [ptm_pkg::SUM_W-1:0]   alu_a;
   logic [ptm_pkg::SUM_W-1:0]   alu_b;
   logic [ptm_pkg::SUM_W-1:0]   alu_res;
   logic                        alu_borrow;

   logic [AW-1:0]     j_prev;
   logic              less;
   logic [AW-1:0]     rank_sum;
   logic              in_win;
   logic [PROD_W-1:0] div_prod;

   assign rd_addr_b = (j_ff == J_END) ? '0 : j_ff[AW-1:0];

   ptm_ram #(
      .WIDTH (ptm_pkg::SAMPLE_W),
      .DEPTH (SAMPLE_COUNT)
   ) u_store (
      .clock     (clock),
      .wr_en     (sample.write),
      .wr_addr   (fill_ff),
      .wr_data   (sample.value),
      .rd_addr_a (i_ff),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   ptm_alu u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_res),
      .borrow (alu_borrow)
   );

   always_comb begin
      // rank of entry i: entries below it, ties broken by position
      j_prev   = AW'(j_ff - 1'b1);
      less     = alu_borrow || ((alu_res == '0) && (j_prev < i_ff));
      rank_sum = rank_ff + AW'(less);
      in_win   = (rank_sum >= WIN_LO) && (rank_sum <= WIN_HI);
      div_prod = PROD_W'(acc_ff) * PROD_W'(ptm_pkg::DIV3_RECIP);

      alu_op = ptm_pkg::ALU_SUB;
      alu_a  = ptm_pkg::SUM_W'(rd_b);
      alu_b  = ptm_pkg::SUM_W'(rd_a);

      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rank_in      = rank_ff;
      fill_in      = fill_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ptm_pkg::ST_IDLE: begin
            if (sample.write) begin
               fill_in = fill_ff + 1'b1;
               if (fill_ff == LAST_IDX) begin
                  fill_in  = '0;
                  state_in = ptm_pkg::ST_SORT;
                  i_in     = '0;
                  j_in     = '0;
                  rank_in  = '0;
                  acc_in   = '0;
               end
            end
         end
         ptm_pkg::ST_SORT: begin
            if (j_ff == J_END) begin
               if (in_win) begin
                  acc_in = acc_ff + ptm_pkg::SUM_W'(rd_a);
               end
               rank_in = '0;
               j_in    = '0;
               if (i_ff == LAST_IDX) begin
                  state_in = ptm_pkg::ST_DIV;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
               if (j_ff != '0) begin
                  rank_in = rank_sum;
               end
            end
         end
         ptm_pkg::ST_DIV: begin
            // divide by three through a reciprocal multiply
            acc_in   = ptm_pkg::SUM_W'(div_prod[PROD_W-1:ptm_pkg::DIV3_SHIFT]);
            state_in = ptm_pkg::ST_OUT;
         end
         ptm_pkg::ST_OUT: begin
            alu_op = ptm_pkg::ALU_ADD;
            alu_a  = acc_ff;
            alu_b  = ptm_pkg::SUM_W'(result_offset);
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = alu_res[ptm_pkg::AVG_W-1:0];
               state_in     = ptm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptm_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      rank_ff     <= rank_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign ready            = (state_ff == ptm_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_average_time = rsp_data_ff;

endmodule

// File: rtl/pulse_capture_trimmed_mean.sv
// Pulse width / period capture with a trimmed-mean filter.
// req channel: one beat per timer event. tuser carries the overflow, edge_seen
// and edge_rising flags, tdata the 16-bit capture count latched at the edge.
// Events that do not complete the sample buffer leave req_tready high, and
// the next beat may follow at once.
// Each nonzero measurement is written to a sample RAM of SAMPLE_COUNT entries.
// The beat that fills it starts the filter: the shared subtract unit ranks
// every entry against every other through the two RAM read ports, then the
// sum of the middle three is divided by three with a reciprocal multiply and
// result_offset is added. req_tready is low for that whole run, and
// rsp_tvalid rises at its end.
// rsp channel: one beat per full buffer, held in an output register; while it
// is stalled, further events are still taken, and only a second result waits
// with req_tready low until the first one is taken.
// csr channel: always ready; index 0 is level_mode, index 1 result_offset.
// Reset clears the measurement state and the sample count, sets level_mode
// to period and result_offset to 3, and drops any pending result.
module pulse_capture_trimmed_mean #(
   parameter int SAMPLE_COUNT = ptm_pkg::SAMPLE_COUNT_DEF,
   parameter int WRAP_LIMIT   = ptm_pkg::WRAP_LIMIT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ptm_pkg::CAP_W-1:0]       req_tdata,  // capture_count
   input  logic [ptm_pkg::REQ_USER_W-1:0]  req_tuser,  // overflow, edge_seen, edge_rising

   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ptm_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // average_time, zero pad

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ptm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ptm_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic                         mode_ff;
   logic [ptm_pkg::OFFSET_W-1:0] offset_ff;

   logic                       accept;
   logic                       flt_ready;
   ptm_pkg::sample_type        sample;
   logic [ptm_pkg::AVG_W-1:0]  average_time;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         offset_ff <= ptm_pkg::OFFSET_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            ptm_pkg::CSR_LEVEL_MODE:    mode_ff   <= csr_data[0];
            ptm_pkg::CSR_RESULT_OFFSET: offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = flt_ready;
   assign accept     = req_tvalid && flt_ready;

   ptm_capture #(
      .WRAP_LIMIT (WRAP_LIMIT)
   ) u_capture (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .overflow      (req_tuser[0]),
      .edge_seen     (req_tuser[1]),
      .edge_rising   (req_tuser[2]),
      .capture_count (req_tdata),
      .level_mode    (mode_ff),
      .sample        (sample)
   );

   ptm_filter #(
      .SAMPLE_COUNT (SAMPLE_COUNT)
   ) u_filter (
      .clock            (clock),
      .reset            (reset),
      .sample           (sample),
      .result_offset    (offset_ff),
      .ready            (flt_ready),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_average_time (average_time)
   );

   assign rsp_tdata = ptm_pkg::RSP_DATA_W'(average_time);

endmodule
